// ===== rtl/core/itr_pkg.sv =====
package itr_pkg;

    localparam logic [10:0] ArmMinId   = 11'h700;
    localparam logic [3:0]  SfMaxLen   = 4'd7;
    localparam logic [12:0] CountMax   = 13'h1fff;
    localparam logic [7:0]  StMsMax    = 8'd127;
    localparam logic [7:0]  StUsLow    = 8'hf1;
    localparam logic [7:0]  StUsHigh   = 8'hf9;
    localparam logic [16:0] SepReserved = 17'd127000;
    localparam logic [9:0]  UsPerMs    = 10'd1000;
    localparam logic [6:0]  UsPerStep  = 7'd100;

    typedef enum logic [2:0] {
        EV_BYTE      = 3'd0,
        EV_DONE      = 3'd1,
        EV_FLOW_SEND = 3'd2,
        EV_ABORT     = 3'd3,
        EV_FLOW_RECV = 3'd4,
        EV_REJECT    = 3'd5
    } t_event;

    typedef enum logic [3:0] {
        PCI_SINGLE      = 4'd0,
        PCI_FIRST       = 4'd1,
        PCI_CONSECUTIVE = 4'd2,
        PCI_FLOW        = 4'd3
    } t_pci;

    typedef enum logic [1:0] {
        SEL_PRE,
        SEL_BYTE,
        SEL_POST
    } t_emit_sel;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PRE,
        ST_BYTES,
        ST_POST
    } t_state;

    typedef struct packed {
        logic      load;
        logic      emit;
        t_emit_sel sel;
    } t_dp_cmd;

    typedef struct packed {
        logic has_pre;
        logic has_bytes;
        logic has_post;
        logic post_pending;
        logic last_byte;
        logic out_free;
    } t_dp_status;

endpackage

// ===== rtl/core/isotp_receive_reassembler.sv =====
// channel  | valid    | ready        | payload
// input    | i_valid  | o_ready      | i_kind i_can_id i_reply_id i_dlc i_byte0..i_byte7
// output   | o_valid  | i_out_ready  | o_event_res o_payload_byte o_message_length
//          |          |              | o_target_id o_block_size o_separation_us
//
// an item is accepted while the sequencer is idle, then its results are put out one after another
// the emission sequencer puts out at most one result per cycle through one output register
// o_ready is high only while the sequencer is idle
// a stalled output holds the sequencer in place; reset is synchronous, active low
module isotp_receive_reassembler #(
    parameter int MAX_MESSAGE = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_kind,
    input  logic [10:0] i_can_id,
    input  logic [10:0] i_reply_id,
    input  logic [3:0]  i_dlc,
    input  logic [7:0]  i_byte0,
    input  logic [7:0]  i_byte1,
    input  logic [7:0]  i_byte2,
    input  logic [7:0]  i_byte3,
    input  logic [7:0]  i_byte4,
    input  logic [7:0]  i_byte5,
    input  logic [7:0]  i_byte6,
    input  logic [7:0]  i_byte7,
    output logic        o_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_event_res,
    output logic [7:0]  o_payload_byte,
    output logic [12:0] o_message_length,
    output logic [10:0] o_target_id,
    output logic [7:0]  o_block_size,
    output logic [16:0] o_separation_us
);
    import itr_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    itr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    itr_datapath #(
        .MAX_MESSAGE (MAX_MESSAGE)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_kind           (i_kind),
        .i_can_id         (i_can_id),
        .i_reply_id       (i_reply_id),
        .i_dlc            (i_dlc),
        .i_byte0          (i_byte0),
        .i_byte1          (i_byte1),
        .i_byte2          (i_byte2),
        .i_byte3          (i_byte3),
        .i_byte4          (i_byte4),
        .i_byte5          (i_byte5),
        .i_byte6          (i_byte6),
        .i_byte7          (i_byte7),
        .o_valid          (o_valid),
        .i_ready          (i_out_ready),
        .o_event_res      (o_event_res),
        .o_payload_byte   (o_payload_byte),
        .o_message_length (o_message_length),
        .o_target_id      (o_target_id),
        .o_block_size     (o_block_size),
        .o_separation_us  (o_separation_us)
    );

endmodule

// ===== rtl/core/itr_ctrl.sv =====
module itr_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  itr_pkg::t_dp_status i_status,
    output itr_pkg::t_dp_cmd    o_cmd
);
    import itr_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_ready    = 1'b0;
        o_cmd.load = 1'b0;
        o_cmd.emit = 1'b0;
        o_cmd.sel  = SEL_PRE;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_status.has_pre) begin
                        n_state = ST_PRE;
                    end else if (i_status.has_bytes) begin
                        n_state = ST_BYTES;
                    end else if (i_status.has_post) begin
                        n_state = ST_POST;
                    end
                end
            end
            ST_PRE: begin
                o_cmd.sel = SEL_PRE;
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_BYTES;
                end
            end
            ST_BYTES: begin
                o_cmd.sel = SEL_BYTE;
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.last_byte) begin
                        n_state = i_status.post_pending ? ST_POST : ST_IDLE;
                    end
                end
            end
            ST_POST: begin
                o_cmd.sel = SEL_POST;
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/itr_datapath.sv =====
module itr_datapath #(
    parameter int MAX_MESSAGE = 4096
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  itr_pkg::t_dp_cmd    i_cmd,
    output itr_pkg::t_dp_status o_status,
    input  logic                i_kind,
    input  logic [10:0]         i_can_id,
    input  logic [10:0]         i_reply_id,
    input  logic [3:0]          i_dlc,
    input  logic [7:0]          i_byte0,
    input  logic [7:0]          i_byte1,
    input  logic [7:0]          i_byte2,
    input  logic [7:0]          i_byte3,
    input  logic [7:0]          i_byte4,
    input  logic [7:0]          i_byte5,
    input  logic [7:0]          i_byte6,
    input  logic [7:0]          i_byte7,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [2:0]          o_event_res,
    output logic [7:0]          o_payload_byte,
    output logic [12:0]         o_message_length,
    output logic [10:0]         o_target_id,
    output logic [7:0]          o_block_size,
    output logic [16:0]         o_separation_us
);
    import itr_pkg::*;

    localparam logic [12:0] MaxLen = 13'(MAX_MESSAGE);

    // receiver state
    logic        r_armed;
    logic [10:0] r_expected_id;
    logic [10:0] r_flow_target;
    logic [12:0] r_declared;
    logic [12:0] r_received;
    logic [3:0]  r_next_seq;

    // item held for emission
    logic [7:0]  r_data [7];
    logic [2:0]  r_byte_idx;
    logic [2:0]  r_byte_left;
    logic        r_post_en;
    t_event      r_post_ev;
    logic [7:0]  r_bs;
    logic [7:0]  r_st;

    // output register
    logic        r_out_valid;
    t_event      r_out_ev;
    logic [7:0]  r_out_byte;
    logic [12:0] r_out_len;
    logic [10:0] r_out_tid;
    logic [7:0]  r_out_bs;
    logic [16:0] r_out_sep;

    logic        frame_ok;
    t_pci        pci_type;
    logic [3:0]  pci_lo;
    logic        d_pre;
    logic [2:0]  d_count;
    logic [2:0]  d_start;
    logic        d_post;
    t_event      d_post_ev;
    logic        seq_match;
    logic [3:0]  dlc_sat;
    logic [2:0]  cf_cnt;
    logic [12:0] cf_diff;
    logic        cf_below;
    logic        cf_done;
    logic [11:0] ff_len;
    logic [13:0] rx_sum;
    logic [12:0] rx_sat;
    logic [16:0] sep_val;

    assign pci_type  = t_pci'(i_byte0[7:4]);
    assign pci_lo    = i_byte0[3:0];
    assign frame_ok  = !i_kind && r_armed && (i_dlc != 4'd0) && (i_can_id == r_expected_id)
                       && (i_byte0[7:6] == 2'b00);
    assign seq_match = (pci_lo == r_next_seq);
    assign dlc_sat   = (i_dlc > 4'd8) ? 4'd8 : i_dlc;
    assign cf_cnt    = 3'(dlc_sat - 4'd1);
    assign cf_below  = (r_received < r_declared);
    assign cf_diff   = r_declared - r_received;
    assign cf_done   = (r_received <= r_declared) && ({10'd0, cf_cnt} >= cf_diff);
    assign ff_len    = {pci_lo, i_byte1};

    always_comb begin
        d_pre     = 1'b0;
        d_count   = 3'd0;
        d_start   = 3'd0;
        d_post    = 1'b0;
        d_post_ev = EV_DONE;
        if (i_kind) begin
            if (i_can_id < ArmMinId) begin
                d_post    = 1'b1;
                d_post_ev = EV_REJECT;
            end
        end else if (frame_ok) begin
            case (pci_type)
                PCI_SINGLE: begin
                    d_count = (pci_lo > SfMaxLen) ? 3'(SfMaxLen) : pci_lo[2:0];
                    d_post  = 1'b1;
                end
                PCI_FIRST: begin
                    d_pre   = 1'b1;
                    d_count = 3'd6;
                    d_start = 3'd1;
                end
                PCI_CONSECUTIVE: begin
                    if (seq_match) begin
                        if (cf_below) begin
                            d_count = (cf_diff < {10'd0, cf_cnt}) ? cf_diff[2:0] : cf_cnt;
                        end
                        d_post = cf_done;
                    end else begin
                        d_post    = 1'b1;
                        d_post_ev = EV_ABORT;
                    end
                end
                PCI_FLOW: begin
                    d_post    = 1'b1;
                    d_post_ev = EV_FLOW_RECV;
                end
                default: begin
                    d_post = 1'b0;
                end
            endcase
        end
    end

    assign rx_sum = {1'b0, r_received} + {11'd0, d_count};
    assign rx_sat = rx_sum[13] ? CountMax : rx_sum[12:0];

    assign o_status.has_pre      = d_pre;
    assign o_status.has_bytes    = (d_count != 3'd0);
    assign o_status.has_post     = d_post;
    assign o_status.post_pending = r_post_en;
    assign o_status.last_byte    = (r_byte_left == 3'd1);
    assign o_status.out_free     = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed       <= 1'b0;
            r_expected_id <= 11'd0;
            r_flow_target <= 11'd0;
            r_declared    <= 13'd0;
            r_received    <= 13'd0;
            r_next_seq    <= 4'd0;
        end else if (i_cmd.load) begin
            if (i_kind) begin
                if (i_can_id >= ArmMinId) begin
                    r_armed       <= 1'b1;
                    r_expected_id <= i_can_id;
                    r_flow_target <= i_reply_id;
                    r_received    <= 13'd0;
                    r_next_seq    <= 4'd1;
                end
            end else if (frame_ok) begin
                case (pci_type)
                    PCI_SINGLE: begin
                        r_declared <= {10'd0, d_count};
                        r_received <= rx_sat;
                        r_armed    <= 1'b0;
                    end
                    PCI_FIRST: begin
                        r_declared <= ({1'b0, ff_len} > MaxLen) ? MaxLen : {1'b0, ff_len};
                        r_received <= rx_sat;
                    end
                    PCI_CONSECUTIVE: begin
                        if (seq_match) begin
                            r_received <= rx_sat;
                            r_next_seq <= r_next_seq + 4'd1;
                            if (cf_done) begin
                                r_armed <= 1'b0;
                            end
                        end else begin
                            r_armed <= 1'b0;
                        end
                    end
                    default: begin
                        r_armed <= r_armed;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_data[0]   <= i_byte1;
            r_data[1]   <= i_byte2;
            r_data[2]   <= i_byte3;
            r_data[3]   <= i_byte4;
            r_data[4]   <= i_byte5;
            r_data[5]   <= i_byte6;
            r_data[6]   <= i_byte7;
            r_byte_idx  <= d_start;
            r_byte_left <= d_count;
            r_post_en   <= d_post;
            r_post_ev   <= d_post_ev;
            r_bs        <= i_byte1;
            r_st        <= i_byte2;
        end else if (i_cmd.emit && i_cmd.sel == SEL_BYTE) begin
            r_byte_idx  <= r_byte_idx + 3'd1;
            r_byte_left <= r_byte_left - 3'd1;
        end
    end

    always_comb begin
        if (r_st <= StMsMax) begin
            sep_val = 17'(r_st) * 17'(UsPerMs);
        end else if (r_st >= StUsLow && r_st <= StUsHigh) begin
            sep_val = 17'(r_st[3:0]) * 17'(UsPerStep);
        end else begin
            sep_val = SepReserved;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_byte <= 8'd0;
            r_out_len  <= 13'd0;
            r_out_tid  <= 11'd0;
            r_out_bs   <= 8'd0;
            r_out_sep  <= 17'd0;
            case (i_cmd.sel)
                SEL_PRE: begin
                    r_out_ev  <= EV_FLOW_SEND;
                    r_out_tid <= r_flow_target;
                end
                SEL_BYTE: begin
                    r_out_ev   <= EV_BYTE;
                    r_out_byte <= r_data[r_byte_idx];
                end
                SEL_POST: begin
                    r_out_ev <= r_post_ev;
                    if (r_post_ev == EV_DONE) begin
                        r_out_len <= r_declared;
                    end
                    if (r_post_ev == EV_FLOW_RECV) begin
                        r_out_bs  <= r_bs;
                        r_out_sep <= sep_val;
                    end
                end
                default: begin
                    r_out_ev <= EV_ABORT;
                end
            endcase
        end
    end

    assign o_valid          = r_out_valid;
    assign o_event_res      = r_out_ev;
    assign o_payload_byte   = r_out_byte;
    assign o_message_length = r_out_len;
    assign o_target_id      = r_out_tid;
    assign o_block_size     = r_out_bs;
    assign o_separation_us  = r_out_sep;

endmodule

// ===== rtl/core/itr_checker.sv =====
module itr_checker #(
    parameter int MAX_MESSAGE = 4096
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_out_ready,
    input logic [2:0]  o_event_res,
    input logic [7:0]  o_payload_byte,
    input logic [12:0] o_message_length,
    input logic [16:0] o_separation_us
);
    import itr_pkg::*;

    localparam logic [12:0] MaxLen = 13'(MAX_MESSAGE);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_out_ready |=> o_valid && $stable(o_event_res)
            && $stable(o_payload_byte))
        else $error("output transfer changed while stalled");

    a_byte_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_event_res != EV_BYTE |-> o_payload_byte == 8'd0)
        else $error("payload byte on a non-byte event");

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_event_res == EV_DONE |-> o_message_length <= MaxLen)
        else $error("completion length above maximum");

    a_sep_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_separation_us <= SepReserved)
        else $error("separation time out of range");

endmodule

bind isotp_receive_reassembler itr_checker #(.MAX_MESSAGE(MAX_MESSAGE)) u_itr_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_out_ready      (i_out_ready),
    .o_event_res      (o_event_res),
    .o_payload_byte   (o_payload_byte),
    .o_message_length (o_message_length),
    .o_separation_us  (o_separation_us)
);

// ===== bench/isotp_rx_checker.sv =====
module isotp_rx_checker #(
    parameter int MAX_MESSAGE = 4096
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_ready,
    input  logic            i_kind,
    input  logic [10:0]     i_can_id,
    input  logic [10:0]     i_reply_id,
    input  logic [3:0]      i_dlc,
    input  logic [7:0][7:0] i_frame_bytes,
    input  logic            i_out_valid,
    input  logic            i_out_ready,
    input  logic [2:0]      i_event_res,
    input  logic [7:0]      i_payload_byte,
    input  logic [12:0]     i_message_length,
    input  logic [10:0]     i_target_id,
    input  logic [7:0]      i_block_size,
    input  logic [16:0]     i_separation_us,
    output int              o_mismatches,
    output int              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import itr_pkg::*;

    typedef struct packed {
        t_event      ev;
        logic [7:0]  data;
        logic [12:0] len;
        logic [10:0] tid;
        logic [7:0]  bs;
        logic [16:0] sep;
    } t_rx_event;

    t_rx_event   rx_events_q[$];
    int          mismatches = 0;

    logic        armed;
    logic [10:0] resp_id;
    logic [10:0] fc_target;
    logic [12:0] msg_len;
    logic [12:0] rx_count;
    logic [3:0]  next_sn;

    assign o_mismatches = mismatches;

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("%0t isotp mismatch: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) begin
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
        end
    endtask

    task automatic queue_event(input t_event ev, input logic [7:0] data,
                               input logic [12:0] len, input logic [10:0] tid,
                               input logic [7:0] bs, input logic [16:0] sep);
        t_rx_event r;
        r.ev   = ev;
        r.data = data;
        r.len  = len;
        r.tid  = tid;
        r.bs   = bs;
        r.sep  = sep;
        rx_events_q.push_back(r);
    endtask

    // streamed byte, count saturates
    task automatic queue_byte(input logic [7:0] data);
        queue_event(EV_BYTE, data, '0, '0, '0, '0);
        if (rx_count != CountMax) begin
            rx_count = rx_count + 13'd1;
        end
    endtask

    task automatic decode_item(input logic kind, input logic [10:0] id,
                               input logic [10:0] rid, input logic [3:0] dlc,
                               input logic [7:0][7:0] d);
        int         i;
        int         n;
        int         flen;
        int         st;
        int         sep;
        logic [3:0] lo;
        lo = d[0][3:0];
        if (kind) begin
            if (id < ArmMinId) begin
                queue_event(EV_REJECT, '0, '0, '0, '0, '0);
            end else begin
                armed     = 1'b1;
                resp_id   = id;
                fc_target = rid;
                rx_count  = '0;
                next_sn   = 4'd1;
            end
        end else if (armed && dlc != 4'd0 && id == resp_id) begin
            case (d[0][7:4])
                PCI_SINGLE: begin
                    n = int'((lo > SfMaxLen) ? SfMaxLen : lo);
                    msg_len = 13'(n);
                    for (i = 0; i < n; i++) begin
                        queue_byte(d[i + 1]);
                    end
                    queue_event(EV_DONE, '0, msg_len, '0, '0, '0);
                    armed = 1'b0;
                end
                PCI_FIRST: begin
                    queue_event(EV_FLOW_SEND, '0, '0, fc_target, '0, '0);
                    flen = int'({lo, d[1]});
                    if (flen > MAX_MESSAGE) begin
                        flen = MAX_MESSAGE;
                    end
                    msg_len = 13'(flen);
                    for (i = 0; i < 6; i++) begin
                        queue_byte(d[i + 2]);
                    end
                end
                PCI_CONSECUTIVE: begin
                    if (lo == next_sn) begin
                        n = ((dlc > 4'd8) ? 8 : int'(dlc)) - 1;
                        for (i = 0; i < n && rx_count < msg_len; i++) begin
                            queue_byte(d[i + 1]);
                        end
                        next_sn = next_sn + 4'd1;
                        if (rx_count == msg_len) begin
                            queue_event(EV_DONE, '0, msg_len, '0, '0, '0);
                            armed = 1'b0;
                        end
                    end else begin
                        queue_event(EV_ABORT, '0, '0, '0, '0, '0);
                        armed = 1'b0;
                    end
                end
                PCI_FLOW: begin
                    st = int'(d[2]);
                    if (st <= StMsMax) begin
                        sep = st * UsPerMs;
                    end else if (st >= StUsLow && st <= StUsHigh) begin
                        sep = (st - StUsLow + 1) * UsPerStep;
                    end else begin
                        sep = int'(SepReserved);
                    end
                    queue_event(EV_FLOW_RECV, '0, '0, '0, d[1], 17'(sep));
                end
                default: begin
                end
            endcase
        end
    endtask

    task automatic check_result();
        t_rx_event want;
        if (rx_events_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result, event %0d", i_event_res));
        end else begin
            want = rx_events_q.pop_front();
            check_field("event", i_event_res, want.ev);
            check_field("payload_byte", i_payload_byte, want.data);
            check_field("message_length", i_message_length, want.len);
            check_field("target_id", i_target_id, want.tid);
            check_field("block_size", i_block_size, want.bs);
            check_field("separation_us", i_separation_us, want.sep);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            armed     = 1'b0;
            resp_id   = '0;
            fc_target = '0;
            msg_len   = '0;
            rx_count  = '0;
            next_sn   = '0;
            rx_events_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                check_result();
            end
            if (i_in_valid && i_in_ready) begin
                decode_item(i_kind, i_can_id, i_reply_id, i_dlc, i_frame_bytes);
            end
        end
        o_pending = rx_events_q.size();
    end

endmodule

// ===== bench/isotp_receive_reassembler_tb.sv =====
module isotp_receive_reassembler_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import itr_pkg::*;

    localparam int TotalItems    = 265;
    localparam int HoldOffCycles = 400;
    localparam int DrainCycles   = 16;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_valid = 1'b0;
    logic            i_kind = 1'b0;
    logic [10:0]     i_can_id = '0;
    logic [10:0]     i_reply_id = '0;
    logic [3:0]      i_dlc = '0;
    logic [7:0][7:0] tx_bytes = '0;
    logic            i_out_ready = 1'b0;

    logic            o_ready;
    logic            o_valid;
    logic [2:0]      o_event_res;
    logic [7:0]      o_payload_byte;
    logic [12:0]     o_message_length;
    logic [10:0]     o_target_id;
    logic [7:0]      o_block_size;
    logic [16:0]     o_separation_us;

    int              mismatches;
    int              pending;
    int              burst_left = 0;
    int              items_sent = 0;
    bit              hold_off_req = 1'b0;

    always #5 i_clk = ~i_clk;

    isotp_receive_reassembler #(
        .MAX_MESSAGE(4096)
    ) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_kind           (i_kind),
        .i_can_id         (i_can_id),
        .i_reply_id       (i_reply_id),
        .i_dlc            (i_dlc),
        .i_byte0          (tx_bytes[0]),
        .i_byte1          (tx_bytes[1]),
        .i_byte2          (tx_bytes[2]),
        .i_byte3          (tx_bytes[3]),
        .i_byte4          (tx_bytes[4]),
        .i_byte5          (tx_bytes[5]),
        .i_byte6          (tx_bytes[6]),
        .i_byte7          (tx_bytes[7]),
        .o_valid          (o_valid),
        .i_out_ready      (i_out_ready),
        .o_event_res      (o_event_res),
        .o_payload_byte   (o_payload_byte),
        .o_message_length (o_message_length),
        .o_target_id      (o_target_id),
        .o_block_size     (o_block_size),
        .o_separation_us  (o_separation_us)
    );

    isotp_rx_checker #(
        .MAX_MESSAGE(4096)
    ) u_rx_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_valid),
        .i_in_ready       (o_ready),
        .i_kind           (i_kind),
        .i_can_id         (i_can_id),
        .i_reply_id       (i_reply_id),
        .i_dlc            (i_dlc),
        .i_frame_bytes    (tx_bytes),
        .i_out_valid      (o_valid),
        .i_out_ready      (i_out_ready),
        .i_event_res      (o_event_res),
        .i_payload_byte   (o_payload_byte),
        .i_message_length (o_message_length),
        .i_target_id      (o_target_id),
        .i_block_size     (o_block_size),
        .i_separation_us  (o_separation_us),
        .o_mismatches     (mismatches),
        .o_pending        (pending)
    );

    function automatic logic [7:0][7:0] rand_bytes();
        return {$urandom, $urandom};
    endfunction

    // separation codes, biased toward the range edges
    function automatic logic [7:0] pick_st();
        if ($urandom_range(0, 1)) begin
            return 8'($urandom_range(0, 255));
        end
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'h7f;
            2: return 8'h80;
            3: return 8'hf0;
            4: return 8'hf1;
            5: return 8'hf9;
            6: return 8'hfa;
            default: return 8'hff;
        endcase
    endfunction

    // sender bursts: valid stays high inside a burst, with a gap of valid low between bursts
    task automatic send_item(input logic kind, input logic [10:0] id, input logic [10:0] rid,
                             input logic [3:0] dlc, input logic [7:0][7:0] d);
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_valid    <= 1'b1;
        i_kind     <= kind;
        i_can_id   <= id;
        i_reply_id <= rid;
        i_dlc      <= dlc;
        tx_bytes   <= d;
        do @(posedge i_clk); while (!o_ready);
        items_sent++;
    endtask

    task automatic send_frame(input logic [10:0] id, input logic [3:0] dlc,
                              input logic [7:0][7:0] d);
        send_item(1'b0, id, 11'($urandom_range(0, 2047)), dlc, d);
    endtask

    task automatic arm_rx(input logic [10:0] id, input logic [10:0] rid);
        send_item(1'b1, id, rid, 4'($urandom_range(0, 15)), rand_bytes());
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    // first frame plus consecutive frames, optionally with noise, flow control and bad sequence
    task automatic run_long_message(input logic [11:0] len, input bit faults);
        logic [10:0]     id;
        logic [7:0][7:0] d;
        logic [3:0]      sn;
        logic [3:0]      bad_sn;
        logic [3:0]      dlc;
        int              rcv;
        int              spare;
        id = 11'($urandom_range(ArmMinId, 11'h7ff));
        arm_rx(id, 11'($urandom_range(0, 2047)));
        d = rand_bytes();
        d[0] = {PCI_FIRST, len[11:8]};
        d[1] = len[7:0];
        send_frame(id, 4'($urandom_range(1, 15)), d);
        rcv = 6;
        sn = 4'd1;
        spare = (len < 6) ? 2 : 0;
        while (rcv < len || spare > 0) begin
            if (faults && $urandom_range(0, 99) < 8) begin
                send_frame(11'($urandom_range(0, 2047)), 4'($urandom_range(0, 15)),
                           rand_bytes());
            end
            if (faults && $urandom_range(0, 99) < 5) begin
                d = rand_bytes();
                d[0][7:4] = PCI_FLOW;
                d[2] = pick_st();
                send_frame(id, 4'($urandom_range(1, 15)), d);
            end
            d = rand_bytes();
            if (faults && $urandom_range(0, 99) < 3) begin
                bad_sn = sn + 4'($urandom_range(1, 15));
                d[0] = {PCI_CONSECUTIVE, bad_sn};
                send_frame(id, 4'($urandom_range(1, 15)), d);
                rcv = len;
                spare = 0;
            end else begin
                dlc = ($urandom_range(0, 9) < 8) ? 4'd8 : 4'($urandom_range(1, 15));
                d[0] = {PCI_CONSECUTIVE, sn};
                send_frame(id, dlc, d);
                rcv += ((dlc > 4'd8) ? 8 : int'(dlc)) - 1;
                sn = sn + 4'd1;
                if (spare > 0) begin
                    spare--;
                end
            end
        end
    endtask

    // receiver: changing stall patterns, plus one long hold-off on request
    initial begin
        int mode;
        int mode_left;
        mode = 0;
        mode_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                i_out_ready <= 1'b0;
                repeat (HoldOffCycles) @(posedge i_clk);
                hold_off_req = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= 1'($urandom_range(0, 1));
                    2: i_out_ready <= ($urandom_range(0, 7) == 0);
                    default: i_out_ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    initial begin
        #2_000_000;
        $display("isotp_receive_reassembler_tb failed");
        $finish;
    end

    initial begin
        logic [7:0][7:0] d;
        logic [5:0][7:0] st_list;
        logic [10:0]     id;
        int              sel;
        int              i;
        st_list = {8'hff, 8'hf9, 8'hf1, 8'h80, 8'h7f, 8'h00};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // frame while not armed
        d = rand_bytes();
        d[0] = 8'h07;
        send_frame(11'h7e8, 4'd8, d);
        // arm ids below the allowed range
        arm_rx(11'h6ff, 11'h7e0);
        arm_rx(11'h000, 11'h7ff);
        // full single frame
        arm_rx(11'h7e8, 11'h7e0);
        d = rand_bytes();
        d[0] = 8'h07;
        send_frame(11'h7e8, 4'd8, d);
        // single frame length saturates, dlc has no effect
        arm_rx(11'h7ff, 11'h000);
        d = rand_bytes();
        d[0] = 8'h0f;
        send_frame(11'h7ff, 4'd1, d);
        // zero length single frame
        arm_rx(11'h700, 11'h555);
        d = rand_bytes();
        d[0] = 8'h00;
        send_frame(11'h700, 4'd15, d);
        // first frame then two consecutive frames, second with dlc above 8
        arm_rx(11'h7e8, 11'h7e0);
        d = rand_bytes();
        d[0] = 8'h10;
        d[1] = 8'd20;
        send_frame(11'h7e8, 4'd8, d);
        d = rand_bytes();
        d[0] = 8'h21;
        send_frame(11'h7e8, 4'd8, d);
        d = rand_bytes();
        d[0] = 8'h22;
        send_frame(11'h7e8, 4'd15, d);
        // largest declared length, flow control codes, then sequence abort
        arm_rx(11'h7a0, 11'h2aa);
        d = rand_bytes();
        d[0] = 8'h1f;
        d[1] = 8'hff;
        send_frame(11'h7a0, 4'd8, d);
        for (i = 0; i < 6; i++) begin
            d = rand_bytes();
            d[0] = 8'h30;
            d[1] = i[0] ? 8'hff : 8'h00;
            d[2] = st_list[i];
            send_frame(11'h7a0, 4'd3, d);
        end
        d = rand_bytes();
        d[0] = 8'h25;
        send_frame(11'h7a0, 4'd8, d);
        // declared length below six: overrun, nothing more streams
        arm_rx(11'h7e8, 11'h7e0);
        d = rand_bytes();
        d[0] = 8'h10;
        d[1] = 8'h03;
        send_frame(11'h7e8, 4'd8, d);
        d = rand_bytes();
        d[0] = 8'h21;
        send_frame(11'h7e8, 4'd8, d);
        // ignored: other id, zero dlc, reserved frame type
        d[0] = 8'h22;
        send_frame(11'h7e9, 4'd8, d);
        send_frame(11'h7e8, 4'd0, d);
        d[0] = 8'h4f;
        send_frame(11'h7e8, 4'd8, d);
        // consecutive frame before any first frame uses the stale length
        arm_rx(11'h7e8, 11'h7e0);
        d = rand_bytes();
        d[0] = 8'h21;
        send_frame(11'h7e8, 4'd8, d);
        wait_drained();

        // receiver holds off while frames keep coming
        hold_off_req = 1'b1;
        run_long_message(12'd60, 1'b0);
        wait_drained();

        while (items_sent < TotalItems) begin
            sel = $urandom_range(0, 99);
            if (sel < 50) begin
                if ($urandom_range(0, 19) == 0) begin
                    run_long_message(12'($urandom_range(200, 400)), 1'b1);
                end else begin
                    run_long_message(12'($urandom_range(1, 80)), 1'b1);
                end
            end else if (sel < 68) begin
                id = 11'($urandom_range(ArmMinId, 11'h7ff));
                arm_rx(id, 11'($urandom_range(0, 2047)));
                d = rand_bytes();
                d[0][7:4] = PCI_SINGLE;
                send_frame(id, 4'($urandom_range(1, 15)), d);
            end else if (sel < 82) begin
                repeat ($urandom_range(1, 4)) begin
                    send_item(1'($urandom_range(0, 1)), 11'($urandom_range(0, 2047)),
                              11'($urandom_range(0, 2047)), 4'($urandom_range(0, 15)),
                              rand_bytes());
                end
            end else if (sel < 90) begin
                id = 11'($urandom_range(ArmMinId, 11'h7ff));
                arm_rx(id, 11'($urandom_range(0, 2047)));
                d = rand_bytes();
                d[0] = {PCI_CONSECUTIVE, 4'd1};
                send_frame(id, 4'($urandom_range(1, 15)), d);
            end else begin
                id = 11'($urandom_range(ArmMinId, 11'h7ff));
                arm_rx(id, 11'($urandom_range(0, 2047)));
                repeat ($urandom_range(1, 3)) begin
                    d = rand_bytes();
                    d[0][7:4] = PCI_FLOW;
                    d[2] = pick_st();
                    send_frame(id, 4'($urandom_range(1, 15)), d);
                end
            end
            if ($urandom_range(0, 11) == 0) begin
                wait_drained();
            end
        end
        wait_drained();

        if (mismatches == 0 && pending == 0) begin
            $display("isotp_receive_reassembler_tb passed");
        end else begin
            $display("isotp_receive_reassembler_tb failed");
        end
        $finish;
    end

endmodule
